// ===== hdl/ifv_pkg.sv =====
// ----------------------------------------------------------------------------
// ifv_pkg
// Widths and UTF-8 limits shared by the frame validator and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package ifv_pkg;

  localparam int DATA_W        = 8;
  localparam int NAME_LEN_W    = 8;
  localparam int ARG_CNT_W     = 2;
  localparam int ARG_LEN_W     = 16;
  localparam int REPORTED_ARGS = 3;
  localparam int ACC_W         = 32;
  localparam int CP_W          = 21;

  localparam logic [7:0] LEAD2_MIN = 8'hc2;
  localparam logic [7:0] LEAD2_MAX = 8'hdf;
  localparam logic [7:0] LEAD3_MIN = 8'he0;
  localparam logic [7:0] LEAD3_MAX = 8'hef;
  localparam logic [7:0] LEAD4_MIN = 8'hf0;
  localparam logic [7:0] LEAD4_MAX = 8'hf4;
  localparam logic [7:0] ASCII_MAX = 8'h7f;

  localparam logic [CP_W-1:0] CP_MIN2      = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN3      = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN4      = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10ffff;
  localparam logic [CP_W-1:0] SURROGATE_LO = 21'h00d800;
  localparam logic [CP_W-1:0] SURROGATE_HI = 21'h00dfff;

  localparam logic [15:0] NAME_LEN_LIMIT = 16'd255;

  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/ifv_in_if.sv =====
// ----------------------------------------------------------------------------
// ifv_in_if
// Byte channel into the frame validator: one frame byte and its end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifv_in_if;
  logic                        valid;
  logic                        ready;
  logic [ifv_pkg::DATA_W-1:0]  data_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/ifv_out_if.sv =====
// ----------------------------------------------------------------------------
// ifv_out_if
// Result channel of the frame validator: verdict and declared lengths.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifv_out_if;
  logic                            valid;
  logic                            ready;
  logic                            frame_valid;
  logic [ifv_pkg::NAME_LEN_W-1:0]  name_length;
  logic [ifv_pkg::ARG_CNT_W-1:0]   arg_count;
  logic [ifv_pkg::ARG_LEN_W-1:0]   first_arg_length;
  logic [ifv_pkg::ARG_LEN_W-1:0]   second_arg_length;
  logic [ifv_pkg::ARG_LEN_W-1:0]   third_arg_length;

  modport source (output valid, output frame_valid, output name_length, output arg_count,
                  output first_arg_length, output second_arg_length,
                  output third_arg_length, input ready);
  modport sink   (input valid, input frame_valid, input name_length, input arg_count,
                  input first_arg_length, input second_arg_length,
                  input third_arg_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/invocation_frame_validator.sv =====
// ----------------------------------------------------------------------------
// invocation_frame_validator
// Parses a request frame byte by byte and reports its verdict and lengths.
// ----------------------------------------------------------------------------
// channel  dir  per transfer
// in_ch    in   data_byte, last_byte
// out_ch   out  frame_valid, name_length, arg_count, three argument lengths
//
// One byte per cycle while in_ch.ready is high; each byte is parsed by the
// state register and the next-state logic in the cycle it is taken. The
// result is registered at the transfer of a last byte and offered in the
// next cycle. in_ch.ready is low only while a result waits and
// out_ch.ready is low. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module invocation_frame_validator #(
  parameter int MAX_ARGS      = 3,
  parameter int MAX_NAME_LEN  = 255,
  parameter int MAX_FRAME_LEN = 65535
) (
  input  wire       clk,
  input  wire       rst_n,
  ifv_in_if.sink    in_ch,
  ifv_out_if.source out_ch
);

  localparam int CNT_W  = $clog2(MAX_FRAME_LEN + 2);
  localparam int FL_W   = $clog2(MAX_FRAME_LEN + 1);
  localparam int LEFT_W = (FL_W < 8) ? 8 : FL_W;
  localparam int CA_W   = (MAX_ARGS < 2) ? 1 : $clog2(MAX_ARGS + 1);
  localparam int RA     = ifv_pkg::REPORTED_ARGS;
  localparam int ACC_W  = ifv_pkg::ACC_W;
  localparam int CP_W   = ifv_pkg::CP_W;
  localparam int LEN_W  = ifv_pkg::ARG_LEN_W;

  localparam logic [2:0] PH_NLEN_LO = 3'd0;
  localparam logic [2:0] PH_NLEN_HI = 3'd1;
  localparam logic [2:0] PH_NAME    = 3'd2;
  localparam logic [2:0] PH_CNT_LO  = 3'd3;
  localparam logic [2:0] PH_CNT_HI  = 3'd4;
  localparam logic [2:0] PH_ALEN    = 3'd5;
  localparam logic [2:0] PH_ADATA   = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  logic [2:0]        phase_r, phase_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [7:0]        nlen_r, nlen_nxt;
  logic [CA_W-1:0]   decl_r, decl_nxt;
  logic [CA_W-1:0]   cur_r, cur_nxt;
  logic [LEN_W-1:0]  tbl_r [RA];
  logic [LEN_W-1:0]  tbl_nxt [RA];
  logic [1:0]        upend_r, upend_nxt;
  logic [CP_W-1:0]   ucp_r, ucp_nxt;
  logic [1:0]        ucls_r, ucls_nxt;
  logic              err_r, err_nxt;
  logic [CNT_W-1:0]  bcnt_r, bcnt_nxt;

  logic              out_valid_r;
  logic              res_valid_r;
  logic [7:0]        res_nlen_r;
  logic [1:0]        res_cnt_r;
  logic [LEN_W-1:0]  res_len_r [RA];
  logic              res_valid_nxt;
  logic [LEN_W-1:0]  res_len_nxt [RA];

  logic              take;
  logic              take_last;
  logic [7:0]        b;
  logic [CP_W-1:0]   cp_min;
  logic [CA_W-1:0]   cur_inc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign take_last   = take && in_ch.last_byte;
  assign b           = in_ch.data_byte;
  assign cur_inc     = cur_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    nlen_nxt  = nlen_r;
    decl_nxt  = decl_r;
    cur_nxt   = cur_r;
    tbl_nxt   = tbl_r;
    upend_nxt = upend_r;
    ucp_nxt   = ucp_r;
    ucls_nxt  = ucls_r;
    err_nxt   = err_r;
    bcnt_nxt  = bcnt_r;
    cp_min    = ifv_pkg::CP_MIN4;

    if (bcnt_r <= CNT_W'(MAX_FRAME_LEN)) begin
      bcnt_nxt = bcnt_r + 1'b1;
    end
    if (bcnt_nxt > CNT_W'(MAX_FRAME_LEN)) begin
      err_nxt = 1'b1;
    end

    if (!err_nxt) begin
      unique case (phase_r)
        PH_NLEN_LO: begin
          acc_nxt   = ACC_W'(b);
          phase_nxt = PH_NLEN_HI;
        end
        PH_NLEN_HI: begin
          acc_nxt[15:8] = b;
          if (acc_nxt[15:0] == 16'd0 || acc_nxt[15:0] > ifv_pkg::NAME_LEN_LIMIT ||
              32'(acc_nxt[15:0]) > MAX_NAME_LEN) begin
            err_nxt = 1'b1;
          end else begin
            nlen_nxt  = acc_nxt[7:0];
            left_nxt  = LEFT_W'(acc_nxt[7:0]);
            phase_nxt = PH_NAME;
          end
        end
        PH_NAME: begin
          if (upend_r == 2'd0) begin
            if (b <= ifv_pkg::ASCII_MAX) begin
              upend_nxt = 2'd0;
            end else if (b >= ifv_pkg::LEAD2_MIN && b <= ifv_pkg::LEAD2_MAX) begin
              ucp_nxt   = CP_W'(b[4:0]);
              upend_nxt = 2'd1;
              ucls_nxt  = ifv_pkg::SEQ_TWO;
            end else if (b >= ifv_pkg::LEAD3_MIN && b <= ifv_pkg::LEAD3_MAX) begin
              ucp_nxt   = CP_W'(b[3:0]);
              upend_nxt = 2'd2;
              ucls_nxt  = ifv_pkg::SEQ_THREE;
            end else if (b >= ifv_pkg::LEAD4_MIN && b <= ifv_pkg::LEAD4_MAX) begin
              ucp_nxt   = CP_W'(b[2:0]);
              upend_nxt = 2'd3;
              ucls_nxt  = ifv_pkg::SEQ_FOUR;
            end else begin
              err_nxt = 1'b1;
            end
          end else if (b[7:6] != 2'b10) begin
            err_nxt = 1'b1;
          end else begin
            ucp_nxt   = {ucp_r[CP_W-7:0], b[5:0]};
            upend_nxt = upend_r - 1'b1;
            if (upend_nxt == 2'd0) begin
              if (ucls_r == ifv_pkg::SEQ_TWO) begin
                cp_min = ifv_pkg::CP_MIN2;
              end else if (ucls_r == ifv_pkg::SEQ_THREE) begin
                cp_min = ifv_pkg::CP_MIN3;
              end
              if (ucp_nxt < cp_min || ucp_nxt > ifv_pkg::CP_MAX ||
                  (ucp_nxt >= ifv_pkg::SURROGATE_LO && ucp_nxt <= ifv_pkg::SURROGATE_HI)) begin
                err_nxt = 1'b1;
              end
            end
          end
          if (!err_nxt) begin
            left_nxt = left_r - 1'b1;
            if (left_nxt == '0) begin
              if (upend_nxt != 2'd0) begin
                err_nxt = 1'b1;
              end
              phase_nxt = PH_CNT_LO;
            end
          end
        end
        PH_CNT_LO: begin
          acc_nxt   = ACC_W'(b);
          phase_nxt = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          acc_nxt[15:8] = b;
          if (32'(acc_nxt[15:0]) > MAX_ARGS) begin
            err_nxt = 1'b1;
          end else begin
            decl_nxt = acc_nxt[CA_W-1:0];
            cur_nxt  = '0;
            if (acc_nxt[15:0] == 16'd0) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_ALEN;
              idx_nxt   = 2'd0;
              acc_nxt   = '0;
            end
          end
        end
        PH_ALEN: begin
          acc_nxt[8*idx_r +: 8] = b;
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 2'd3) begin
            if (acc_nxt > ACC_W'(MAX_FRAME_LEN)) begin
              err_nxt = 1'b1;
            end else begin
              for (int k = 0; k < RA; k++) begin
                if (32'(cur_r) == k) begin
                  tbl_nxt[k] = acc_nxt[LEN_W-1:0];
                end
              end
              if (acc_nxt == '0) begin
                cur_nxt = cur_inc;
                if (cur_inc >= decl_r) begin
                  phase_nxt = PH_DONE;
                end else begin
                  idx_nxt = 2'd0;
                  acc_nxt = '0;
                end
              end else begin
                left_nxt  = acc_nxt[LEFT_W-1:0];
                phase_nxt = PH_ADATA;
              end
            end
          end
        end
        PH_ADATA: begin
          left_nxt = left_r - 1'b1;
          if (left_nxt == '0) begin
            cur_nxt = cur_inc;
            if (cur_inc >= decl_r) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_ALEN;
              idx_nxt   = 2'd0;
              acc_nxt   = '0;
            end
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end

    res_valid_nxt = !err_nxt && phase_nxt == PH_DONE;
    for (int k = 0; k < RA; k++) begin
      res_len_nxt[k] = (res_valid_nxt && 32'(decl_nxt) > k) ? tbl_nxt[k] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || take_last) begin
      phase_r <= PH_NLEN_LO;
      idx_r   <= '0;
      left_r  <= '0;
      acc_r   <= '0;
      nlen_r  <= '0;
      decl_r  <= '0;
      cur_r   <= '0;
      upend_r <= '0;
      ucp_r   <= '0;
      ucls_r  <= '0;
      err_r   <= 1'b0;
      bcnt_r  <= '0;
      for (int k = 0; k < RA; k++) begin
        tbl_r[k] <= '0;
      end
    end else if (take) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      nlen_r  <= nlen_nxt;
      decl_r  <= decl_nxt;
      cur_r   <= cur_nxt;
      upend_r <= upend_nxt;
      ucp_r   <= ucp_nxt;
      ucls_r  <= ucls_nxt;
      err_r   <= err_nxt;
      bcnt_r  <= bcnt_nxt;
      tbl_r   <= tbl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      res_valid_r <= res_valid_nxt;
      res_nlen_r  <= res_valid_nxt ? nlen_nxt : 8'd0;
      res_cnt_r   <= res_valid_nxt ? 2'(decl_nxt) : 2'd0;
      res_len_r   <= res_len_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.frame_valid       = res_valid_r;
  assign out_ch.name_length       = res_nlen_r;
  assign out_ch.arg_count         = res_cnt_r;
  assign out_ch.first_arg_length  = res_len_r[0];
  assign out_ch.second_arg_length = res_len_r[1];
  assign out_ch.third_arg_length  = res_len_r[2];

  a_parse_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    take_last |=> (phase_r == PH_NLEN_LO && !err_r && bcnt_r == '0))
    else $error("parser state not cleared after last byte");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take_last))
    else $error("result raised without a last-byte transfer");

  a_invalid_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_valid_r) |->
      (res_nlen_r == 8'd0 && res_cnt_r == 2'd0 && res_len_r[0] == '0 &&
       res_len_r[1] == '0 && res_len_r[2] == '0))
    else $error("invalid frame reports nonzero fields");

  a_valid_has_name: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_valid_r) |-> res_nlen_r != 8'd0)
    else $error("valid frame with empty name");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && take && !in_ch.last_byte) |=> err_r)
    else $error("error flag dropped inside a frame");

endmodule

`default_nettype wire

// ===== tb/tb_invocation_frame_validator.sv =====
// ----------------------------------------------------------------------------
// tb_invocation_frame_validator
// Self-checking bench for the request frame validator. A fixed table of short
// frames with pinned verdicts covers a minimal valid frame and the main
// rejection cases. After that come random frames, mostly well formed with
// random content, and some broken, truncated, padded or pure noise, whose
// verdicts a parser model in the bench predicts. Each result transfer is
// compared field by field with the oldest one due. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_invocation_frame_validator;

  localparam int ARG_LIMIT      = 3;
  localparam int NAME_LIMIT     = 255;
  localparam int FRAME_LIMIT    = 65535;
  localparam int RANDOM_OCTETS  = 1450;
  localparam int MAX_WAIT       = 17;
  localparam int SETTLE_CYCLES  = 20;

  typedef logic [7:0] octet_t;

  typedef struct packed {
    logic                           frame_valid;
    logic [ifv_pkg::NAME_LEN_W-1:0] name_length;
    logic [ifv_pkg::ARG_CNT_W-1:0]  arg_count;
    logic [ifv_pkg::ARG_LEN_W-1:0]  first_arg_length;
    logic [ifv_pkg::ARG_LEN_W-1:0]  second_arg_length;
    logic [ifv_pkg::ARG_LEN_W-1:0]  third_arg_length;
  } verdict_t;

  typedef struct packed {
    octet_t   data_byte;
    logic     last_byte;
    logic     pinned;
    verdict_t want;
  } directed_row_t;

  typedef enum logic [3:0] {
    AWAIT_NLEN_LO, AWAIT_NLEN_HI, IN_NAME, AWAIT_CNT_LO, AWAIT_CNT_HI,
    IN_ARG_LEN, IN_ARG_DATA, FRAME_DONE
  } parse_phase_t;

  typedef enum int {
    FLAW_NONE, FLAW_TRUNCATE, FLAW_TRAILING, FLAW_SMASH, FLAW_NAME_LEN,
    FLAW_COUNT, FLAW_ARG_LEN, FLAW_UTF8, FLAW_NOISE
  } frame_flaw_t;

  typedef enum int {
    BAD_OVERLONG2, BAD_OVERLONG3, BAD_SURROGATE, BAD_OVERLONG4, BAD_ABOVE_MAX,
    BAD_LEAD, BAD_STRAY, BAD_BROKEN, BAD_TRUNCATED
  } bad_utf8_t;

  localparam verdict_t REJECTED      = '0;
  localparam verdict_t ONE_CHAR_NAME = '{1'b1, 8'd1, 2'd0, 16'd0, 16'd0, 16'd0};

  logic clk = 1'b0;
  logic rst_n;

  ifv_in_if  in_ch ();
  ifv_out_if out_ch ();

  invocation_frame_validator #(
    .MAX_ARGS      (ARG_LIMIT),
    .MAX_NAME_LEN  (NAME_LIMIT),
    .MAX_FRAME_LEN (FRAME_LIMIT)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  directed_row_t directed_rows [26] = '{
    '{8'h01, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'h7f, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b1, 1'b1, ONE_CHAR_NAME},
    '{8'hff, 1'b1, 1'b1, REJECTED},
    '{8'h01, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'h41, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'h5a, 1'b1, 1'b1, REJECTED},
    '{8'h01, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'hc3, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b1, 1'b1, REJECTED},
    '{8'h01, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'h41, 1'b0, 1'b0, REJECTED},
    '{8'h01, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b0, 1'b0, REJECTED},
    '{8'h01, 1'b0, 1'b0, REJECTED},
    '{8'h00, 1'b1, 1'b1, REJECTED}
  };

  // parser model state
  parse_phase_t                phase;
  logic [2:0]                  len_octet_idx;
  logic [15:0]                 field_left;
  logic [31:0]                 len_acc;
  logic [7:0]                  kept_name_len;
  logic [1:0]                  kept_count;
  logic [1:0]                  arg_idx;
  logic [15:0]                 arg_len_seen [ifv_pkg::REPORTED_ARGS];
  logic [1:0]                  utf8_left;
  logic [ifv_pkg::CP_W-1:0]    utf8_cp;
  logic [1:0]                  utf8_class;
  logic                        frame_bad;
  logic [16:0]                 octets_seen;

  verdict_t    verdicts_due [$];
  octet_t      frame_bytes [$];
  octet_t      name_bytes [$];
  int unsigned mismatches;
  int unsigned live_octets;
  bit          tx_calm;
  bit          rx_calm;

  function automatic void clear_parser();
    phase         = AWAIT_NLEN_LO;
    len_octet_idx = '0;
    field_left    = '0;
    len_acc       = '0;
    kept_name_len = '0;
    kept_count    = '0;
    arg_idx       = '0;
    foreach (arg_len_seen[i]) arg_len_seen[i] = '0;
    utf8_left     = '0;
    utf8_cp       = '0;
    utf8_class    = '0;
    frame_bad     = 1'b0;
    octets_seen   = '0;
  endfunction

  function automatic void take_name_octet(octet_t b);
    logic [ifv_pkg::CP_W-1:0] floor_cp;
    if (utf8_left == 0) begin
      if (b <= ifv_pkg::ASCII_MAX) return;
      if (b >= ifv_pkg::LEAD2_MIN && b <= ifv_pkg::LEAD2_MAX) begin
        utf8_cp = {16'd0, b[4:0]};
        utf8_left = 2'd1;
        utf8_class = ifv_pkg::SEQ_TWO;
      end else if (b >= ifv_pkg::LEAD3_MIN && b <= ifv_pkg::LEAD3_MAX) begin
        utf8_cp = {17'd0, b[3:0]};
        utf8_left = 2'd2;
        utf8_class = ifv_pkg::SEQ_THREE;
      end else if (b >= ifv_pkg::LEAD4_MIN && b <= ifv_pkg::LEAD4_MAX) begin
        utf8_cp = {18'd0, b[2:0]};
        utf8_left = 2'd3;
        utf8_class = ifv_pkg::SEQ_FOUR;
      end else begin
        frame_bad = 1'b1;
      end
      return;
    end
    if (b[7:6] != 2'b10) begin
      frame_bad = 1'b1;
      return;
    end
    utf8_cp = {utf8_cp[ifv_pkg::CP_W-7:0], b[5:0]};
    utf8_left = utf8_left - 2'd1;
    if (utf8_left == 0) begin
      floor_cp = (utf8_class == ifv_pkg::SEQ_TWO) ? ifv_pkg::CP_MIN2 :
                 (utf8_class == ifv_pkg::SEQ_THREE) ? ifv_pkg::CP_MIN3 : ifv_pkg::CP_MIN4;
      if (utf8_cp < floor_cp || utf8_cp > ifv_pkg::CP_MAX ||
          (utf8_cp >= ifv_pkg::SURROGATE_LO && utf8_cp <= ifv_pkg::SURROGATE_HI))
        frame_bad = 1'b1;
    end
  endfunction

  function automatic void advance_arg();
    arg_idx = arg_idx + 2'd1;
    if (arg_idx >= kept_count) begin
      phase = FRAME_DONE;
    end else begin
      phase = IN_ARG_LEN;
      len_octet_idx = '0;
      len_acc = '0;
    end
  endfunction

  function automatic void take_octet(octet_t b);
    case (phase)
      AWAIT_NLEN_LO: begin
        len_acc = {24'd0, b};
        phase = AWAIT_NLEN_HI;
      end
      AWAIT_NLEN_HI: begin
        len_acc = len_acc | {16'd0, b, 8'd0};
        if (len_acc == 0 || len_acc > ifv_pkg::NAME_LEN_LIMIT || len_acc > NAME_LIMIT) begin
          frame_bad = 1'b1;
        end else begin
          kept_name_len = len_acc[7:0];
          field_left = len_acc[15:0];
          phase = IN_NAME;
        end
      end
      IN_NAME: begin
        take_name_octet(b);
        field_left = field_left - 16'd1;
        if (field_left == 0) begin
          if (utf8_left != 0) frame_bad = 1'b1;
          phase = AWAIT_CNT_LO;
        end
      end
      AWAIT_CNT_LO: begin
        len_acc = {24'd0, b};
        phase = AWAIT_CNT_HI;
      end
      AWAIT_CNT_HI: begin
        len_acc = len_acc | {16'd0, b, 8'd0};
        if (len_acc > ARG_LIMIT) begin
          frame_bad = 1'b1;
        end else begin
          kept_count = len_acc[1:0];
          arg_idx = '0;
          if (kept_count == 0) begin
            phase = FRAME_DONE;
          end else begin
            phase = IN_ARG_LEN;
            len_octet_idx = '0;
            len_acc = '0;
          end
        end
      end
      IN_ARG_LEN: begin
        len_acc = len_acc | ({24'd0, b} << (8 * len_octet_idx[1:0]));
        len_octet_idx = len_octet_idx + 3'd1;
        if (len_octet_idx >= 4) begin
          if (len_acc > FRAME_LIMIT) begin
            frame_bad = 1'b1;
          end else begin
            if (arg_idx < ARG_LIMIT) arg_len_seen[arg_idx] = len_acc[15:0];
            if (len_acc == 0) begin
              advance_arg();
            end else begin
              field_left = len_acc[15:0];
              phase = IN_ARG_DATA;
            end
          end
        end
      end
      IN_ARG_DATA: begin
        field_left = field_left - 16'd1;
        if (field_left == 0) advance_arg();
      end
      default: frame_bad = 1'b1;
    endcase
  endfunction

  function automatic bit absorb_octet(octet_t b, logic lst, output verdict_t v);
    bit ok;
    if (octets_seen <= FRAME_LIMIT) octets_seen = octets_seen + 17'd1;
    if (octets_seen > FRAME_LIMIT) frame_bad = 1'b1;
    if (!frame_bad) take_octet(b);
    v = '0;
    if (!lst) return 1'b0;
    ok = !frame_bad && phase == FRAME_DONE;
    if (ok) begin
      v.frame_valid       = 1'b1;
      v.name_length       = kept_name_len;
      v.arg_count         = kept_count;
      v.first_arg_length  = (kept_count > 0) ? arg_len_seen[0] : 16'd0;
      v.second_arg_length = (kept_count > 1) ? arg_len_seen[1] : 16'd0;
      v.third_arg_length  = (kept_count > 2) ? arg_len_seen[2] : 16'd0;
    end
    clear_parser();
    return 1'b1;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic check_verdict(input verdict_t got);
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      report_mismatch("result with no frame pending", 32'(got.frame_valid), 32'd0);
      return;
    end
    want = verdicts_due.pop_front();
    if (got.frame_valid !== want.frame_valid)
      report_mismatch("frame_valid", 32'(got.frame_valid), 32'(want.frame_valid));
    if (got.name_length !== want.name_length)
      report_mismatch("name_length", 32'(got.name_length), 32'(want.name_length));
    if (got.arg_count !== want.arg_count)
      report_mismatch("arg_count", 32'(got.arg_count), 32'(want.arg_count));
    if (got.first_arg_length !== want.first_arg_length)
      report_mismatch("first_arg_length", 32'(got.first_arg_length),
                      32'(want.first_arg_length));
    if (got.second_arg_length !== want.second_arg_length)
      report_mismatch("second_arg_length", 32'(got.second_arg_length),
                      32'(want.second_arg_length));
    if (got.third_arg_length !== want.third_arg_length)
      report_mismatch("third_arg_length", 32'(got.third_arg_length),
                      32'(want.third_arg_length));
  endtask

  // enter and leave on a falling edge; valid stays high on return
  task automatic send_octet(input octet_t b, input logic lst, input logic pinned,
                            input verdict_t pinned_want);
    int gap;
    verdict_t v;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    do @(posedge clk); while (!in_ch.ready);
    live_octets++;
    if (absorb_octet(b, lst, v)) verdicts_due.push_back(pinned ? pinned_want : v);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i])
      send_octet(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, REJECTED);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (verdicts_due.size() != 0);
  endtask

  function automatic void put_good_char(int room);
    int cls;
    bit at_boundary;
    logic [ifv_pkg::CP_W-1:0] cp;
    cls = $urandom_range(1, room < 4 ? room : 4);
    at_boundary = ($urandom_range(0, 3) == 0);
    case (cls)
      1: begin
        cp = at_boundary ? ($urandom_range(0, 1) ? 21'h7f : 21'h0)
                         : 21'($urandom_range(0, 'h7f));
        name_bytes.push_back(cp[7:0]);
      end
      2: begin
        cp = at_boundary ? ($urandom_range(0, 1) ? 21'h7ff : ifv_pkg::CP_MIN2)
                         : 21'($urandom_range('h80, 'h7ff));
        name_bytes.push_back({3'b110, cp[10:6]});
        name_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        case ($urandom_range(0, 3))
          0: cp = ifv_pkg::CP_MIN3;
          1: cp = 21'hffff;
          2: cp = ifv_pkg::SURROGATE_LO - 21'd1;
          default: cp = ifv_pkg::SURROGATE_HI + 21'd1;
        endcase
        if (!at_boundary) cp = 21'($urandom_range('h800, 'hffff));
        if (cp >= ifv_pkg::SURROGATE_LO && cp <= ifv_pkg::SURROGATE_HI) cp = cp ^ 21'h2000;
        name_bytes.push_back({4'b1110, cp[15:12]});
        name_bytes.push_back({2'b10, cp[11:6]});
        name_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        cp = at_boundary ? ($urandom_range(0, 1) ? ifv_pkg::CP_MAX : ifv_pkg::CP_MIN4)
                         : 21'($urandom_range('h10000, 'h10ffff));
        name_bytes.push_back({5'b11110, cp[20:18]});
        name_bytes.push_back({2'b10, cp[17:12]});
        name_bytes.push_back({2'b10, cp[11:6]});
        name_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void fill_name(int target);
    while (name_bytes.size() < target) put_good_char(target - name_bytes.size());
  endfunction

  function automatic octet_t cont_octet();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic octet_t rand_octet(int lo, int hi);
    return octet_t'($urandom_range(lo, hi));
  endfunction

  // returns 1 when the sequence must close the name
  function automatic bit put_bad_seq();
    bad_utf8_t kind;
    int need;
    kind = bad_utf8_t'($urandom_range(BAD_OVERLONG2, BAD_TRUNCATED));
    case (kind)
      BAD_OVERLONG2: begin
        name_bytes.push_back(rand_octet('hc0, 'hc1));
        name_bytes.push_back(cont_octet());
      end
      BAD_OVERLONG3: begin
        name_bytes.push_back(8'he0);
        name_bytes.push_back(rand_octet('h80, 'h9f));
        name_bytes.push_back(cont_octet());
      end
      BAD_SURROGATE: begin
        name_bytes.push_back(8'hed);
        name_bytes.push_back(rand_octet('ha0, 'hbf));
        name_bytes.push_back(cont_octet());
      end
      BAD_OVERLONG4: begin
        name_bytes.push_back(8'hf0);
        name_bytes.push_back(rand_octet('h80, 'h8f));
        name_bytes.push_back(cont_octet());
        name_bytes.push_back(cont_octet());
      end
      BAD_ABOVE_MAX: begin
        name_bytes.push_back(8'hf4);
        name_bytes.push_back(rand_octet('h90, 'hbf));
        name_bytes.push_back(cont_octet());
        name_bytes.push_back(cont_octet());
      end
      BAD_LEAD: name_bytes.push_back(rand_octet('hf5, 'hff));
      BAD_STRAY: name_bytes.push_back(cont_octet());
      BAD_BROKEN: begin
        name_bytes.push_back(rand_octet(ifv_pkg::LEAD2_MIN, ifv_pkg::LEAD4_MAX));
        name_bytes.push_back($urandom_range(0, 1) ? rand_octet(0, 'h7f)
                                                  : rand_octet('hc0, 'hff));
      end
      default: begin
        need = $urandom_range(1, 3);
        case (need)
          1: name_bytes.push_back(rand_octet(ifv_pkg::LEAD2_MIN, ifv_pkg::LEAD2_MAX));
          2: name_bytes.push_back(rand_octet('he1, 'hec));
          default: name_bytes.push_back(rand_octet('hf1, 'hf3));
        endcase
        repeat ($urandom_range(0, need - 1)) name_bytes.push_back(cont_octet());
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void push_le(logic [31:0] value, int octets);
    for (int i = 0; i < octets; i++) frame_bytes.push_back(value[8*i +: 8]);
  endfunction

  function automatic void build_frame();
    frame_flaw_t flaw;
    int pick;
    int name_target;
    int declared_name;
    int count;
    int bad_arg;
    logic [31:0] alen;
    frame_bytes.delete();
    name_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 62) flaw = FLAW_NONE;
    else flaw = frame_flaw_t'($urandom_range(FLAW_TRUNCATE, FLAW_NOISE));
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(rand_octet(0, 255));
      return;
    end
    if ($urandom_range(0, 29) == 0)
      name_target = $urandom_range(0, 1) ? NAME_LIMIT : $urandom_range(240, 254);
    else
      name_target = $urandom_range(1, 10);
    if (flaw == FLAW_UTF8) begin
      fill_name($urandom_range(0, name_target - 1));
      if (!put_bad_seq()) fill_name(name_target);
    end else begin
      fill_name(name_target);
    end
    declared_name = name_bytes.size();
    if (flaw == FLAW_NAME_LEN) begin
      case ($urandom_range(0, 2))
        0: declared_name = 0;
        1: declared_name = NAME_LIMIT + 1;
        default: declared_name = $urandom_range(NAME_LIMIT + 2, 65535);
      endcase
    end
    push_le(declared_name, 2);
    foreach (name_bytes[i]) frame_bytes.push_back(name_bytes[i]);
    count = (flaw == FLAW_ARG_LEN) ? $urandom_range(1, ARG_LIMIT) : $urandom_range(0, ARG_LIMIT);
    push_le((flaw == FLAW_COUNT) ? $urandom_range(ARG_LIMIT + 1, 65535) : count, 2);
    bad_arg = (flaw == FLAW_ARG_LEN) ? $urandom_range(0, count - 1) : -1;
    for (int a = 0; a < count; a++) begin
      pick = $urandom_range(0, 9);
      alen = (pick < 2) ? 0 : (pick < 9) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      if (a == bad_arg) alen = {16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535))};
      push_le(alen, 4);
      if (a == bad_arg) begin
        repeat ($urandom_range(0, 3)) frame_bytes.push_back(rand_octet(0, 255));
        break;
      end
      repeat (alen) frame_bytes.push_back(rand_octet(0, 255));
    end
    case (flaw)
      FLAW_TRUNCATE: frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
      FLAW_TRAILING: repeat ($urandom_range(1, 3)) frame_bytes.push_back(rand_octet(0, 255));
      FLAW_SMASH: frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = rand_octet(0, 255);
      default: ;
    endcase
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        check_verdict('{out_ch.frame_valid, out_ch.name_length, out_ch.arg_count,
                        out_ch.first_arg_length, out_ch.second_arg_length,
                        out_ch.third_arg_length});
        stall = draw_wait(rx_calm);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    rst_n           = 1'b0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    mismatches      = 0;
    live_octets     = 0;
    clear_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_octet(directed_rows[i].data_byte, directed_rows[i].last_byte,
                 directed_rows[i].pinned, directed_rows[i].want);
    hold_until_drained();

    live_octets = 0;
    while (live_octets < RANDOM_OCTETS) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      rx_calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) hold_until_drained();
      build_frame();
      send_frame();
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_invocation_frame_validator passed");
    end else begin
      $display("tb_invocation_frame_validator failed");
    end
    $finish;
  end

  initial begin
    #(64'd10_000_000);
    $display("tb_invocation_frame_validator failed");
    $finish;
  end

endmodule
